// File: hdl/lsra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsra_pkg
// Shared types and constants for the linear scan register allocator.
// ----------------------------------------------------------------------------
package lsra_pkg;

    localparam int NUM_REGS  = 7;
    localparam int FIRST_REG = 4;
    localparam int ID_W      = 16;
    localparam int POS_W     = 16;
    localparam int REGNO_W   = 4;
    localparam int SLOT_W    = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int CNT_W     = $clog2(NUM_REGS + 1);

    typedef struct packed {
        logic             first_of_pass;
        logic [ID_W-1:0]  interval_id;
        logic [POS_W-1:0] interval_start;
        logic [POS_W-1:0] interval_end;
    } in_item_t;

    typedef struct packed {
        logic               got_register;
        logic [REGNO_W-1:0] register_number;
        logic               victim_valid;
        logic [ID_W-1:0]    victim_id;
        logic               pass_failed;
    } out_item_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [POS_W-1:0]  fin;
        logic [SLOT_W-1:0] slot;
    } act_entry_t;

    typedef struct packed {
        logic load;
        logic expire;
        logic grant;
        logic evict;
        logic reject;
        logic insert;
        logic publish;
    } lsra_cmd_t;

    typedef struct packed {
        logic expire_hit;
        logic pool_free;
        logic victim_ok;
        logic out_busy;
    } lsra_status_t;

endpackage

// File: hdl/linear_scan_register_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_scan_register_allocator
// Grants registers to live intervals, spilling the latest-ending one when full.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+------------------------------
//  request | req_valid, req_ready | req (first_of_pass, id, start, end)
//  result  | rsp_valid, rsp_ready | rsp (grant, register, victim, flag)
//
//  After acceptance an item passes the expiry step, retiring one expired
//  active interval per cycle, then the allocate, insert and publish steps;
//  publish puts its result in the output register. A new interval that
//  spills itself skips the insert step. The next item can be accepted once
//  a result enters the output register, even while that result still waits
//  on rsp_ready; that next item then holds in its last step until it drains.
//  Reset empties the active list, frees every register and clears the flag.
// ----------------------------------------------------------------------------
module linear_scan_register_allocator
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  lsra_pkg::in_item_t  req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output lsra_pkg::out_item_t rsp
);

    lsra_pkg::lsra_cmd_t    cmd;
    lsra_pkg::lsra_status_t st;

    lsra_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .st        (st),
        .cmd       (cmd)
    );

    lsra_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .st        (st),
        .rsp_ready (rsp_ready),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule

// File: hdl/lsra_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsra_ctrl
// Sequencer: accept, expire, allocate or spill, insert, publish.
// ----------------------------------------------------------------------------
module lsra_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  lsra_pkg::lsra_status_t st,
    output lsra_pkg::lsra_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXPIRE = 3'd1;
    localparam logic [2:0] S_ALLOC  = 3'd2;
    localparam logic [2:0] S_INSERT = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXPIRE;
                end
            end
            S_EXPIRE:
            begin
                if (st.expire_hit)
                begin
                    cmd.expire = 1'b1;
                end
                else
                begin
                    state_next = S_ALLOC;
                end
            end
            S_ALLOC:
            begin
                if (st.pool_free)
                begin
                    cmd.grant  = 1'b1;
                    state_next = S_INSERT;
                end
                else if (st.victim_ok)
                begin
                    cmd.evict  = 1'b1;
                    state_next = S_INSERT;
                end
                else
                begin
                    cmd.reject = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_INSERT:
            begin
                cmd.insert = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!st.out_busy)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/lsra_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsra_dp
// Active list, free pool, spill flag and output register.
// ----------------------------------------------------------------------------
module lsra_dp
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  lsra_pkg::in_item_t     req,
    input  lsra_pkg::lsra_cmd_t    cmd,
    output lsra_pkg::lsra_status_t st,
    input  logic                   rsp_ready,
    output logic                   rsp_valid,
    output lsra_pkg::out_item_t    rsp
);

    localparam logic [lsra_pkg::NUM_REGS-1:0] POOL_ALL = '1;

    lsra_pkg::in_item_t   item_reg;
    lsra_pkg::act_entry_t ent_reg [lsra_pkg::NUM_REGS];
    logic [lsra_pkg::CNT_W-1:0]    count_reg;
    logic [lsra_pkg::NUM_REGS-1:0] mask_reg;
    logic                          spill_reg;
    logic                          got_reg;
    logic [lsra_pkg::SLOT_W-1:0]   slot_reg;
    logic                          vvalid_reg;
    logic [lsra_pkg::ID_W-1:0]     vid_reg;
    logic                          out_valid_reg;
    lsra_pkg::out_item_t           out_reg;

    logic [lsra_pkg::SLOT_W-1:0]   low_free;
    logic [lsra_pkg::SLOT_W-1:0]   last_idx;
    logic [lsra_pkg::CNT_W-1:0]    last_cnt;
    lsra_pkg::act_entry_t          last_ent;
    lsra_pkg::act_entry_t          new_ent;
    logic [lsra_pkg::NUM_REGS-1:0] keep;
    logic [lsra_pkg::NUM_REGS-1:0] slot_bit;

    always_comb
    begin
        low_free = '0;
        for (int i = lsra_pkg::NUM_REGS - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                low_free = lsra_pkg::SLOT_W'(i);
            end
        end
    end

    assign last_cnt = count_reg - lsra_pkg::CNT_W'(1);
    assign last_idx = last_cnt[lsra_pkg::SLOT_W-1:0];
    assign last_ent = ent_reg[last_idx];
    assign slot_bit = lsra_pkg::NUM_REGS'(1) << ent_reg[0].slot;

    assign new_ent.id   = item_reg.interval_id;
    assign new_ent.fin  = item_reg.interval_end;
    assign new_ent.slot = slot_reg;

    always_comb
    begin
        for (int i = 0; i < lsra_pkg::NUM_REGS; i++)
        begin
            keep[i] = (lsra_pkg::CNT_W'(i) < count_reg) &&
                      (ent_reg[i].fin <= item_reg.interval_end);
        end
    end

    assign st.expire_hit = (count_reg != '0) && (ent_reg[0].fin < item_reg.interval_start);
    assign st.pool_free  = (mask_reg != '0);
    assign st.victim_ok  = (count_reg != '0) && (last_ent.fin > item_reg.interval_end);
    assign st.out_busy   = out_valid_reg && !rsp_ready;

    // hold item and per-item result fields
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg   <= req;
            got_reg    <= 1'b0;
            vvalid_reg <= 1'b0;
            vid_reg    <= '0;
        end
        if (cmd.grant)
        begin
            slot_reg <= low_free;
            got_reg  <= 1'b1;
        end
        if (cmd.evict)
        begin
            slot_reg   <= last_ent.slot;
            got_reg    <= 1'b1;
            vvalid_reg <= 1'b1;
            vid_reg    <= last_ent.id;
        end
    end

    // active list: shift down on expiry, open a gap on insertion
    always_ff @(posedge clk)
    begin
        if (cmd.expire)
        begin
            for (int i = 0; i < lsra_pkg::NUM_REGS - 1; i++)
            begin
                ent_reg[i] <= ent_reg[i+1];
            end
        end
        else if (cmd.insert && (count_reg < lsra_pkg::CNT_W'(lsra_pkg::NUM_REGS)))
        begin
            for (int i = 0; i < lsra_pkg::NUM_REGS; i++)
            begin
                if (!keep[i])
                begin
                    if (i == 0)
                    begin
                        ent_reg[i] <= new_ent;
                    end
                    else if (keep[i-1])
                    begin
                        ent_reg[i] <= new_ent;
                    end
                    else
                    begin
                        ent_reg[i] <= ent_reg[i-1];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            mask_reg  <= POOL_ALL;
            spill_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load && req.first_of_pass)
            begin
                count_reg <= '0;
                mask_reg  <= POOL_ALL;
                spill_reg <= 1'b0;
            end
            if (cmd.expire)
            begin
                count_reg <= count_reg - lsra_pkg::CNT_W'(1);
                mask_reg  <= mask_reg | slot_bit;
            end
            if (cmd.grant)
            begin
                mask_reg <= mask_reg & ~(lsra_pkg::NUM_REGS'(1) << low_free);
            end
            if (cmd.evict)
            begin
                count_reg <= last_cnt;
                spill_reg <= 1'b1;
            end
            if (cmd.reject)
            begin
                spill_reg <= 1'b1;
            end
            if (cmd.insert && (count_reg < lsra_pkg::CNT_W'(lsra_pkg::NUM_REGS)))
            begin
                count_reg <= count_reg + lsra_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.publish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            out_reg.got_register    <= got_reg;
            out_reg.register_number <= got_reg ?
                lsra_pkg::REGNO_W'(lsra_pkg::FIRST_REG + int'(slot_reg)) : '0;
            out_reg.victim_valid    <= vvalid_reg;
            out_reg.victim_id       <= vid_reg;
            out_reg.pass_failed     <= spill_reg;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

// File: hdl/lsra_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsra_chk
// Port-level checks for the register allocator.
// ----------------------------------------------------------------------------
module lsra_chk
(
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input lsra_pkg::in_item_t  req,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input lsra_pkg::out_item_t rsp
);

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("item accepted while previous item in work");

    a_no_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.got_register) |->
        (rsp.register_number == '0) && rsp.pass_failed)
        else $error("spilled item shows register or no flag");

    a_victim_cons: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.victim_valid) |-> rsp.got_register && rsp.pass_failed)
        else $error("victim without grant or flag");

    a_no_victim_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.victim_valid) |-> (rsp.victim_id == '0))
        else $error("victim id set without victim");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp))
        else $error("stalled result changed");

endmodule

bind linear_scan_register_allocator lsra_chk u_chk (.*);
